@@ rtl/core/scd_pkg.sv @@
// Shared types, constants and the tanh table for the soft clipper with DC blocker.
// Used by scd_div, soft_clipper_dc_block_mix, scd_checker and tb; depends on nothing.
package scd_pkg;

  localparam int unsigned SAMPLE_W     = 24;
  localparam int unsigned CHAN_W       = 3;
  localparam int unsigned DEF_CHANNELS = 8;
  localparam int unsigned CFG_W        = 24;
  localparam int unsigned CFG_IDX_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD   = 3'd0,
    REG_PRE_GAIN    = 3'd1,
    REG_POST_GAIN   = 3'd2,
    REG_BYPASS      = 3'd3,
    REG_DC_FEEDBACK = 3'd4,
    REG_RAMP_LENGTH = 3'd5
  } cfg_reg_e;

  localparam logic [15:0] THR_RESET  = 16'd39493;
  localparam logic [23:0] GAIN_RESET = 24'd65536;
  localparam logic [23:0] FB_RESET   = 24'd16760492;
  localparam logic [15:0] LEN_RESET  = 16'd661;
  localparam logic [23:0] WET_FULL   = 24'd65536;
  localparam logic [23:0] THR_MIN    = 24'd1678;
  localparam logic [23:0] THR_MAX    = 24'd16775538;

  localparam int unsigned DIV_NUM_W = 33;
  localparam int unsigned DIV_DEN_W = 25;
  localparam int unsigned DIV_CNT_W = 6;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] rem;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  localparam int unsigned TANH_DEPTH = 256;
  localparam longint      Q30        = 64'sd1 << 30;
  localparam longint      Q24        = 64'sd1 << 24;

  typedef logic [23:0] tanh_rom_t [TANH_DEPTH+1];

  // Long division of nonnegative values, evaluated only while the table is built.
  function automatic longint udiv(longint num, longint den);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r <<< 1) | ((num >>> b) & 1);
      q = q <<< 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint exp_neg_q30(longint f);
    longint term;
    longint sum;
    term = Q30;
    sum  = Q30;
    for (int k = 1; k <= 24; k++) begin
      term = udiv((term * f) >>> 30, longint'(k));
      sum  = ((k & 1) == 1) ? sum - term : sum + term;
    end
    return sum;
  endfunction

  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t rom;
    longint    e1;
    longint    y;
    longint    e;
    longint    n;
    e1 = exp_neg_q30(Q30);
    for (int i = 0; i <= TANH_DEPTH; i++) begin
      y = udiv(longint'(i) <<< 34, longint'(TANH_DEPTH));
      n = y >>> 30;
      e = exp_neg_q30(y & (Q30 - 1));
      for (longint j = 0; j < n; j++) e = (e * e1) >>> 30;
      if (e > Q30) e = Q30;
      if (e < 0) e = 0;
      rom[i] = 24'(udiv((Q30 - e) * Q24 + ((Q30 + e) >>> 1), Q30 + e));
    end
    return rom;
  endfunction

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

endpackage

@@ rtl/core/scd_div.sv @@
// Bit-serial restoring divider shared by the ramp retarget and the clip quotient.
// Depends on scd_pkg for the request struct and widths.
module scd_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  scd_pkg::div_req_t                req_i,
  output logic                             done_o,
  output logic [scd_pkg::DIV_NUM_W-1:0]    quo_o
);
  import scd_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DEN_W-1:0] rem_q;
  logic [DIV_DEN_W-1:0] den_q;
  logic [DIV_NUM_W-1:0] num_q;
  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;
  logic [DIV_DEN_W:0]   diff;
  logic [DIV_DEN_W-1:0] rem_d;

  always_comb begin
    trial = {rem_q, num_q[DIV_NUM_W-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
    rem_d = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      num_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
        rem_q  <= req_i.rem;
        den_q  <= req_i.den;
        num_q  <= req_i.num;
        quo_q  <= '0;
      end else if (busy_q) begin
        rem_q <= rem_d;
        num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
        quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider started while busy");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && den_q != '0 |-> rem_q < den_q) else $error("partial remainder not below divisor");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && $past(cnt_q) == DIV_CNT_W'(1))
    else $error("done without a final step");

endmodule

@@ rtl/core/soft_clipper_dc_block_mix.sv @@
// Top level: soft clipper with per-channel DC blocker, ramped gains and bypass crossfade.
// Depends on scd_pkg and scd_div.
//
// One word is processed at a time, and in_ready_o is high only while the block is idle.
// A word whose gained magnitude stays at or below the threshold goes from the compare step
// straight to the DC blocker. A clipped word waits for the clip quotient, which comes from
// the bit-serial divider at one bit per cycle; a word so far above the threshold that the
// tanh argument saturates skips the divider. A word with new_frame set first runs the four
// ramp steps, with a division for every ramp whose target changed while the ramp length is
// nonzero. A finished word waits in the output register, and the next word is accepted
// meanwhile. All multiplications share one 28 x 38 bit multiplier.
module soft_clipper_dc_block_mix #(
  parameter int unsigned CHANNELS = scd_pkg::DEF_CHANNELS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [scd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [scd_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [scd_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [scd_pkg::CHAN_W-1:0]          channel_i,
  input  logic                                new_frame_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [scd_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic [scd_pkg::CHAN_W-1:0]          channel_out_o
);
  import scd_pkg::*;

  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [27:0] U_MAX    = 28'h8000000;
  localparam logic [24:0] ONE_Q24  = 25'h1000000;

  typedef enum logic [4:0] {
    S_IDLE, S_RCHK, S_RDIV, S_RSTEP, S_PRE, S_W, S_CMP, S_CDIV, S_TANH, S_TANH2,
    S_CLIPM, S_CLIP2, S_DC, S_DC2, S_POST, S_POST2, S_MIX1, S_MIX2, S_MIX3, S_OUT
  } state_e;

  state_e state_q;

  logic [15:0] thr_q;
  logic [23:0] pre_q;
  logic [23:0] post_q;
  logic        bypass_q;
  logic [23:0] fb_q;
  logic [15:0] len_q;

  logic [31:0]        cur_q [4];
  logic signed [32:0] inc_q [4];
  logic [15:0]        rem_q [4];
  logic [23:0]        tgt_q [4];
  logic [1:0]         rk_q;
  logic               rneg_q;

  logic signed [25:0] dc_x1_q [CHANNELS];
  logic signed [27:0] dc_y1_q [CHANNELS];

  logic signed [25:0] dry_q;
  logic [CHAN_W-1:0]  ch_q;
  logic signed [34:0] w_q;
  logic [27:0]        u_q;
  logic [23:0]        th0_q;
  logic [24:0]        tanh_q;
  logic signed [25:0] c_q;
  logic signed [27:0] y_q;
  logic signed [36:0] p_q;
  logic [24:0]        wv_q;
  logic signed [65:0] acc_q;
  logic signed [43:0] mixed_q;
  logic signed [65:0] prod_q;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] out_q;
  logic [CHAN_W-1:0]          ch_out_q;

  logic [23:0]          tg;
  logic [31:0]          goal;
  logic signed [32:0]   rdiff;
  logic signed [32:0]   rdiff_neg;
  logic [31:0]          rabs;
  logic [15:0]          rem_dec;
  logic [31:0]          cur_add;
  logic [DIV_NUM_W-1:0] quo;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] quo_neg;
  logic [DIV_NUM_W-1:0] inc_new;
  logic [23:0]          t_c;
  logic [24:0]          r_c;
  logic [CH_IDX_W-1:0]  chs;
  logic signed [65:0]   prod_r24;
  logic signed [65:0]   prod_r19;
  logic signed [34:0]   w_neg;
  logic [33:0]          mag;
  logic [33:0]          mdiff;
  logic [27:0]          u_div;
  logic [8:0]           ridx;
  logic [8:0]           ridx1;
  logic [23:0]          th0;
  logic signed [24:0]   tdiff;
  logic [25:0]          cmag;
  logic signed [29:0]   ysum;
  logic signed [27:0]   ysat;
  logic signed [66:0]   msum;
  logic signed [66:0]   mround;
  logic signed [43:0]   oround;
  logic signed [SAMPLE_W-1:0] osat;
  logic signed [27:0]   mul_a;
  logic signed [37:0]   mul_b;
  logic                 mul_en;
  div_req_t             div_req;

  always_comb begin
    case (rk_q)
      2'd0:    tg = {8'b0, thr_q};
      2'd1:    tg = pre_q;
      2'd2:    tg = post_q;
      default: tg = bypass_q ? 24'd0 : WET_FULL;
    endcase
    goal      = {tg, 8'b0};
    rdiff     = $signed({1'b0, goal}) - $signed({1'b0, cur_q[rk_q]});
    rdiff_neg = -rdiff;
    rabs      = rdiff[32] ? rdiff_neg[31:0] : rdiff[31:0];
    rem_dec   = rem_q[rk_q] - 16'd1;
    cur_add   = cur_q[rk_q] + inc_q[rk_q][31:0];
    quo_neg   = -quo;
    inc_new   = rneg_q ? quo_neg : quo;

    if (cur_q[0] < {8'b0, THR_MIN}) begin
      t_c = THR_MIN;
    end else if (cur_q[0] > {8'b0, THR_MAX}) begin
      t_c = THR_MAX;
    end else begin
      t_c = cur_q[0][23:0];
    end
    r_c = ONE_Q24 - {1'b0, t_c};

    if (32'(ch_q) >= 32'(CHANNELS)) begin
      chs = CH_IDX_W'(CHANNELS - 1);
    end else begin
      chs = ch_q[CH_IDX_W-1:0];
    end

    prod_r24 = (prod_q + 66'sd8388608) >>> 24;
    prod_r19 = (prod_q + 66'sd262144) >>> 19;

    w_neg = -w_q;
    mag   = w_q[34] ? w_neg[33:0] : w_q[33:0];
    mdiff = mag - {10'b0, t_c};
    u_div = (quo[27:0] > U_MAX) ? U_MAX : quo[27:0];

    ridx  = u_q[27:19];
    ridx1 = ridx + 9'd1;
    if (ridx[8]) begin
      th0   = TANH_ROM[TANH_DEPTH];
      tdiff = '0;
    end else begin
      th0   = TANH_ROM[ridx];
      tdiff = $signed({1'b0, TANH_ROM[ridx1]}) - $signed({1'b0, TANH_ROM[ridx]});
    end

    cmag = {2'b0, t_c} + prod_r24[25:0];
    ysum = 30'(c_q) - 30'(dc_x1_q[chs]) + $signed(prod_r24[29:0]);
    if (ysum[29:27] == 3'b000 || ysum[29:27] == 3'b111) begin
      ysat = ysum[27:0];
    end else begin
      ysat = ysum[29] ? {1'b1, 27'b0} : {1'b0, {27{1'b1}}};
    end

    msum   = 67'(acc_q) + 67'(prod_q);
    mround = (msum + 67'sd8388608) >>> 24;
    oround = (mixed_q + 44'sd1) >>> 1;
    if (oround[43:23] == '0 || oround[43:23] == '1) begin
      osat = oround[SAMPLE_W-1:0];
    end else begin
      osat = oround[43] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      S_PRE: begin
        mul_a = 28'(dry_q);
        mul_b = {6'b0, cur_q[1]};
      end
      S_TANH: begin
        mul_a = {9'b0, u_q[18:0]};
        mul_b = 38'(tdiff);
      end
      S_CLIPM: begin
        mul_a = {3'b0, r_c};
        mul_b = {13'b0, tanh_q};
      end
      S_DC: begin
        mul_a = dc_y1_q[chs];
        mul_b = {14'b0, fb_q};
      end
      S_POST: begin
        mul_a = y_q;
        mul_b = {6'b0, cur_q[2]};
      end
      S_MIX1: begin
        mul_a = 28'(dry_q);
        mul_b = {13'b0, ONE_Q24 - wv_q};
      end
      S_MIX2: begin
        mul_a = {3'b0, wv_q};
        mul_b = 38'(p_q);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_comb begin
    div_req = '0;
    case (state_q)
      S_RCHK: begin
        div_req.start = (tg != tgt_q[rk_q]) && (len_q != 16'd0);
        div_req.num   = {1'b0, rabs};
        div_req.den   = {9'b0, len_q};
        div_req.steps = DIV_CNT_W'(33);
      end
      S_CMP: begin
        div_req.start = (mag > {10'b0, t_c}) && (mdiff < {5'b0, r_c, 4'b0});
        div_req.num   = {mdiff[3:0], 29'b0};
        div_req.rem   = mdiff[28:4];
        div_req.den   = r_c;
        div_req.steps = DIV_CNT_W'(28);
      end
      default: div_req = '0;
    endcase
  end

  scd_div u_div_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      thr_q       <= THR_RESET;
      pre_q       <= GAIN_RESET;
      post_q      <= GAIN_RESET;
      bypass_q    <= 1'b0;
      fb_q        <= FB_RESET;
      len_q       <= LEN_RESET;
      tgt_q[0]    <= {8'b0, THR_RESET};
      tgt_q[1]    <= GAIN_RESET;
      tgt_q[2]    <= GAIN_RESET;
      tgt_q[3]    <= WET_FULL;
      cur_q[0]    <= {8'b0, THR_RESET, 8'b0};
      cur_q[1]    <= {GAIN_RESET, 8'b0};
      cur_q[2]    <= {GAIN_RESET, 8'b0};
      cur_q[3]    <= {WET_FULL, 8'b0};
      for (int k = 0; k < 4; k++) begin
        inc_q[k] <= '0;
        rem_q[k] <= '0;
      end
      for (int i = 0; i < CHANNELS; i++) begin
        dc_x1_q[i] <= '0;
        dc_y1_q[i] <= '0;
      end
      rk_q        <= '0;
      rneg_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      ch_out_q    <= '0;
      dry_q       <= '0;
      ch_q        <= '0;
      w_q         <= '0;
      u_q         <= '0;
      th0_q       <= '0;
      tanh_q      <= '0;
      c_q         <= '0;
      y_q         <= '0;
      p_q         <= '0;
      wv_q        <= '0;
      acc_q       <= '0;
      mixed_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_THRESHOLD:   thr_q    <= cfg_data_i[15:0];
          REG_PRE_GAIN:    pre_q    <= cfg_data_i;
          REG_POST_GAIN:   post_q   <= cfg_data_i;
          REG_BYPASS:      bypass_q <= cfg_data_i[0];
          REG_DC_FEEDBACK: fb_q     <= cfg_data_i;
          REG_RAMP_LENGTH: len_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && state_q != S_OUT) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            dry_q   <= {sample_in_i[SAMPLE_W-1], sample_in_i, 1'b0};
            ch_q    <= channel_i;
            rk_q    <= '0;
            state_q <= new_frame_i ? S_RCHK : S_PRE;
          end
        end
        S_RCHK: begin
          if (tg != tgt_q[rk_q]) begin
            tgt_q[rk_q] <= tg;
            if (len_q == 16'd0) begin
              cur_q[rk_q] <= goal;
              rem_q[rk_q] <= '0;
              state_q     <= S_RSTEP;
            end else begin
              rem_q[rk_q] <= len_q;
              rneg_q      <= rdiff[32];
              state_q     <= S_RDIV;
            end
          end else begin
            state_q <= S_RSTEP;
          end
        end
        S_RDIV: begin
          if (div_done) begin
            inc_q[rk_q] <= $signed(inc_new);
            state_q     <= S_RSTEP;
          end
        end
        S_RSTEP: begin
          if (rem_q[rk_q] != 16'd0) begin
            rem_q[rk_q] <= rem_dec;
            cur_q[rk_q] <= (rem_dec != 16'd0) ? cur_add : {tgt_q[rk_q], 8'b0};
          end
          if (rk_q == 2'd3) begin
            state_q <= S_PRE;
          end else begin
            rk_q    <= rk_q + 2'd1;
            state_q <= S_RCHK;
          end
        end
        S_PRE: state_q <= S_W;
        S_W: begin
          w_q     <= prod_r24[34:0];
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (mag <= {10'b0, t_c}) begin
            c_q     <= w_q[25:0];
            state_q <= S_DC;
          end else if (mdiff >= {5'b0, r_c, 4'b0}) begin
            u_q     <= U_MAX;
            state_q <= S_TANH;
          end else begin
            state_q <= S_CDIV;
          end
        end
        S_CDIV: begin
          if (div_done) begin
            u_q     <= u_div;
            state_q <= S_TANH;
          end
        end
        S_TANH: begin
          th0_q   <= th0;
          state_q <= S_TANH2;
        end
        S_TANH2: begin
          tanh_q  <= {1'b0, th0_q} + prod_r19[24:0];
          state_q <= S_CLIPM;
        end
        S_CLIPM: state_q <= S_CLIP2;
        S_CLIP2: begin
          c_q     <= w_q[34] ? -$signed(cmag) : $signed(cmag);
          state_q <= S_DC;
        end
        S_DC: state_q <= S_DC2;
        S_DC2: begin
          y_q          <= ysat;
          dc_x1_q[chs] <= c_q;
          dc_y1_q[chs] <= ysat;
          state_q      <= S_POST;
        end
        S_POST: state_q <= S_POST2;
        S_POST2: begin
          p_q     <= prod_r24[36:0];
          wv_q    <= (cur_q[3] > {7'b0, ONE_Q24}) ? ONE_Q24 : cur_q[3][24:0];
          state_q <= S_MIX1;
        end
        S_MIX1: state_q <= S_MIX2;
        S_MIX2: begin
          acc_q   <= prod_q;
          state_q <= S_MIX3;
        end
        S_MIX3: begin
          mixed_q <= mround[43:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_q       <= osat;
            ch_out_q    <= ch_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign sample_out_o  = out_q;
  assign channel_out_o = ch_out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != S_IDLE) else $error("accepted word not processed");
  a_tanh_arg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_TANH |-> u_q <= U_MAX) else $error("tanh argument above table range");
  a_div_start_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> state_q == S_CMP || state_q == S_RCHK)
    else $error("divider started outside a division step");
  a_mix_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MIX1 |-> wv_q <= ONE_Q24) else $error("wet amount out of range");

endmodule

@@ tb/sv/scd_checker.sv @@
// Checker for the soft clipper with DC blocker: watches the register port and both word
// channels, predicts every output word and compares it field by field. Depends on scd_pkg.
module scd_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [scd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [scd_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [scd_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic [scd_pkg::CHAN_W-1:0]          channel_i,
  input  logic                                new_frame_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [scd_pkg::SAMPLE_W-1:0] sample_out_i,
  input  logic [scd_pkg::CHAN_W-1:0]          channel_out_i,
  output int                                  err_cnt_o,
  output int                                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import scd_pkg::*;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CHAN_W-1:0]          chan;
  } clip_word_t;

  localparam longint ONE_Q24 = 64'sd1 << 24;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint ARG_MAX = 64'sd1 << 27;

  clip_word_t  expected_words[$];
  longint      tanh_tab[TANH_DEPTH+1];
  logic [15:0] thr_reg;
  logic [23:0] pre_reg;
  logic [23:0] post_reg;
  logic        bypass_reg;
  logic [23:0] fb_reg;
  logic [15:0] len_reg;
  longint      dc_x[DEF_CHANNELS];
  longint      dc_y[DEF_CHANNELS];
  longint      ramp_cur[4];
  longint      ramp_inc[4];
  longint      ramp_left[4];
  longint      ramp_goal[4];

  function automatic longint rnd_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint sat(longint v, int bits);
    longint hi;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
  endfunction

  function automatic longint decay_q30(longint f);
    longint term;
    longint acc;
    term = ONE_Q30;
    acc  = ONE_Q30;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * f) >>> 30) / k;
      acc  = (k % 2 == 1) ? acc - term : acc + term;
    end
    return acc;
  endfunction

  initial begin
    longint e1;
    longint y;
    longint e;
    e1 = decay_q30(ONE_Q30);
    for (int i = 0; i <= TANH_DEPTH; i++) begin
      y = (longint'(i) <<< 34) / TANH_DEPTH;
      e = decay_q30(y & (ONE_Q30 - 1));
      for (longint j = 0; j < (y >>> 30); j++) e = (e * e1) >>> 30;
      if (e > ONE_Q30) e = ONE_Q30;
      if (e < 0) e = 0;
      tanh_tab[i] = ((ONE_Q30 - e) * ONE_Q24 + (ONE_Q30 + e) / 2) / (ONE_Q30 + e);
    end
  end

  function automatic longint tanh_lookup(longint u);
    longint pos;
    longint idx;
    if (u > ARG_MAX) u = ARG_MAX;
    pos = u * TANH_DEPTH;
    idx = pos >>> 27;
    if (idx >= TANH_DEPTH) return tanh_tab[TANH_DEPTH];
    return tanh_tab[idx] + rnd_shift((tanh_tab[idx+1] - tanh_tab[idx]) * (pos & (ARG_MAX - 1)), 27);
  endfunction

  function automatic longint clip_level(longint w, longint t);
    longint mag;
    longint r;
    longint c;
    if (t < longint'(THR_MIN)) t = THR_MIN;
    if (t > longint'(THR_MAX)) t = THR_MAX;
    mag = w < 0 ? -w : w;
    if (mag <= t) return w;
    r = ONE_Q24 - t;
    c = t + rnd_shift(r * tanh_lookup(((mag - t) * ONE_Q24) / r), 24);
    return w < 0 ? -c : c;
  endfunction

  function automatic longint ramp_aim(int k);
    case (k)
      0: return longint'(thr_reg);
      1: return longint'(pre_reg);
      2: return longint'(post_reg);
      default: return bypass_reg ? 0 : longint'(WET_FULL);
    endcase
  endfunction

  function automatic void step_ramps();
    longint aim;
    for (int k = 0; k < 4; k++) begin
      aim = ramp_aim(k);
      if (aim != ramp_goal[k]) begin
        ramp_goal[k] = aim;
        if (len_reg == 0) begin
          ramp_cur[k]  = aim <<< 8;
          ramp_left[k] = 0;
        end else begin
          ramp_left[k] = len_reg;
          ramp_inc[k]  = ((aim <<< 8) - ramp_cur[k]) / longint'(len_reg);
        end
      end
      if (ramp_left[k] > 0) begin
        ramp_left[k]--;
        if (ramp_left[k] > 0) ramp_cur[k] += ramp_inc[k];
        else ramp_cur[k] = ramp_goal[k] <<< 8;
      end
    end
  endfunction

  function automatic clip_word_t process_word(logic signed [SAMPLE_W-1:0] s,
                                              logic [CHAN_W-1:0] ch, logic nf);
    clip_word_t res;
    longint     dry;
    longint     c;
    longint     y;
    longint     p;
    longint     wv;
    longint     o;
    int         idx;
    idx = ch < DEF_CHANNELS ? int'(ch) : DEF_CHANNELS - 1;
    if (nf) step_ramps();
    dry = longint'(s) * 2;
    c   = clip_level(rnd_shift(dry * ramp_cur[1], 24), ramp_cur[0]);
    y   = sat(c - dc_x[idx] + rnd_shift(longint'(fb_reg) * dc_y[idx], 24), 28);
    dc_x[idx] = c;
    dc_y[idx] = y;
    p  = rnd_shift(y * ramp_cur[2], 24);
    wv = ramp_cur[3];
    if (wv < 0) wv = 0;
    if (wv > ONE_Q24) wv = ONE_Q24;
    o = sat(rnd_shift(rnd_shift(dry * (ONE_Q24 - wv) + p * wv, 24), 1), SAMPLE_W);
    res.sample = o[SAMPLE_W-1:0];
    res.chan   = ch;
    return res;
  endfunction

  assign pending_o = expected_words.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    clip_word_t exp_w;
    int         n_err;
    if (!rst_ni) begin
      thr_reg    <= THR_RESET;
      pre_reg    <= GAIN_RESET;
      post_reg   <= GAIN_RESET;
      bypass_reg <= 1'b0;
      fb_reg     <= FB_RESET;
      len_reg    <= LEN_RESET;
      for (int k = 0; k < DEF_CHANNELS; k++) begin
        dc_x[k] = 0;
        dc_y[k] = 0;
      end
      ramp_goal[0] = THR_RESET;
      ramp_goal[1] = GAIN_RESET;
      ramp_goal[2] = GAIN_RESET;
      ramp_goal[3] = WET_FULL;
      for (int k = 0; k < 4; k++) begin
        ramp_cur[k]  = ramp_goal[k] <<< 8;
        ramp_inc[k]  = 0;
        ramp_left[k] = 0;
      end
      expected_words.delete();
      err_cnt_o <= 0;
    end else begin
      n_err = 0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_THRESHOLD:   thr_reg    <= cfg_data_i[15:0];
          REG_PRE_GAIN:    pre_reg    <= cfg_data_i;
          REG_POST_GAIN:   post_reg   <= cfg_data_i;
          REG_BYPASS:      bypass_reg <= cfg_data_i[0];
          REG_DC_FEEDBACK: fb_reg     <= cfg_data_i;
          REG_RAMP_LENGTH: len_reg    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("Output word with no word expected: sample_out %0d", sample_out_i);
          n_err = n_err + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (sample_out_i !== exp_w.sample) begin
            $error("sample_out: expected %0d, got %0d", exp_w.sample, sample_out_i);
            n_err = n_err + 1;
          end
          if (channel_out_i !== exp_w.chan) begin
            $error("channel_out: expected %0d, got %0d", exp_w.chan, channel_out_i);
            n_err = n_err + 1;
          end
        end
      end
      if (n_err != 0) err_cnt_o <= err_cnt_o + n_err;
      if (in_valid_i && in_ready_i)
        expected_words.push_back(process_word(sample_in_i, channel_i, new_frame_i));
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for soft_clipper_dc_block_mix: clock, reset, register writes and word
// stimulus with random gaps and stalls. Depends on scd_pkg, scd_checker and the block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scd_pkg::*;

  localparam int STALL_LIMIT = 5000;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_idx = REG_THRESHOLD;
  logic [CFG_W-1:0]            cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [SAMPLE_W-1:0]  sample_in = '0;
  logic [CHAN_W-1:0]           channel = '0;
  logic                        new_frame = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0]  sample_out;
  logic [CHAN_W-1:0]           channel_out;
  int                          err_cnt;
  int                          pending;
  int                          quiet_cycles = 0;
  logic                        no_idle = 1'b0;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  soft_clipper_dc_block_mix i_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .sample_in_i(sample_in), .channel_i(channel), .new_frame_i(new_frame),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .sample_out_o(sample_out), .channel_out_o(channel_out)
  );

  scd_checker i_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .sample_in_i(sample_in), .channel_i(channel), .new_frame_i(new_frame),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .sample_out_i(sample_out), .channel_out_i(channel_out),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = pick_gap();
      @(negedge clk_i);
      out_ready = (stall == 0);
      if (stall > 0) begin
        repeat (stall - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_ready = 1'b1;
      end
      repeat ($urandom_range(0, 8)) @(negedge clk_i);
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic send_word(logic signed [SAMPLE_W-1:0] s, logic [CHAN_W-1:0] ch, logic nf);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid  = 1'b1;
    sample_in = s;
    channel   = ch;
    new_frame = nf;
    do @(posedge clk_i); while (!in_ready);
  endtask

  function automatic logic [CFG_W-1:0] pick_setting(int bits, bit allow_zero);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return allow_zero ? '0 : CFG_W'(1);
    if (r == 1) return (CFG_W'(1) << bits) - CFG_W'(1);
    if (r < 6) return CFG_W'($urandom_range(0, 7));
    return CFG_W'($urandom()) & ((CFG_W'(1) << bits) - CFG_W'(1));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return SAMPLE_W'($urandom());
    if (r < 8) return SAMPLE_W'(int'($urandom_range(0, 131071)) - 65536);
    return r == 8 ? 24'sh7fffff : 24'sh800000;
  endfunction

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, every channel, ramps on and off, hard clipping.
    send_word(24'sh7fffff, 3'd0, 1'b0);
    send_word(24'sh800000, 3'd7, 1'b1);
    send_word(24'sh000000, 3'd3, 1'b0);
    send_word(-24'sd1, 3'd5, 1'b1);
    for (int c = 0; c < 8; c++) send_word(pick_sample(), CHAN_W'(c), c[0]);
    drain_results();
    write_reg(REG_RAMP_LENGTH, 24'd0);
    write_reg(REG_PRE_GAIN, 24'hffffff);
    write_reg(REG_THRESHOLD, 24'd0);
    write_reg(REG_DC_FEEDBACK, 24'hffffff);
    send_word(24'sh400000, 3'd1, 1'b1);
    send_word(24'shc00000, 3'd1, 1'b0);
    send_word(24'sh000010, 3'd2, 1'b1);
    drain_results();
    write_reg(REG_THRESHOLD, 24'hffff);
    write_reg(REG_BYPASS, 24'd1);
    write_reg(REG_POST_GAIN, 24'hffffff);
    write_reg(REG_DC_FEEDBACK, 24'd0);
    write_reg(REG_RAMP_LENGTH, 24'd3);
    for (int i = 0; i < 6; i++) send_word(i[0] ? 24'sh7fffff : 24'sh800000, 3'd4, 1'b1);

    for (int ph = 0; ph < 12; ph++) begin
      drain_results();
      if (ph == 11) write_reg(REG_RAMP_LENGTH, 24'hffff);
      else write_reg(REG_RAMP_LENGTH, pick_setting(16, 1'b1));
      write_reg(REG_THRESHOLD, $urandom_range(0, 3) == 0 ? pick_setting(16, 1'b1)
                                                          : CFG_W'($urandom_range(7, 65529)));
      write_reg(REG_PRE_GAIN, $urandom_range(0, 2) == 0 ? pick_setting(24, 1'b1)
                                                         : CFG_W'($urandom_range(16384, 400000)));
      write_reg(REG_POST_GAIN, $urandom_range(0, 2) == 0 ? pick_setting(24, 1'b1)
                                                          : CFG_W'($urandom_range(16384, 200000)));
      write_reg(REG_BYPASS, CFG_W'($urandom_range(0, 1)));
      write_reg(REG_DC_FEEDBACK, $urandom_range(0, 2) == 0 ? pick_setting(24, 1'b1)
                                                            : 24'hff0000 | CFG_W'($urandom()));
      no_idle = (ph % 4 == 2);
      for (int i = 0; i < 112; i++) begin
        if (ph == 5 && i == 56) drain_results();
        send_word(pick_sample(), CHAN_W'($urandom()), 1'($urandom_range(0, 1)));
      end
    end

    @(negedge clk_i);
    in_valid = 1'b0;
    drain_results();
    repeat (60) @(negedge clk_i);
    if (err_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
